[rtl/c2d_pkg.sv]
// c2d_pkg: shared sizes, codes, types and helpers for the Q8.8 valid convolution block.
// No dependencies; used by conv2d_valid_q8_8_top and c2d_mac.
`timescale 1ns / 1ps
`default_nettype none

package c2d_pkg;

	// Sizing
	localparam int MAX_IMAGE  = 64;
	localparam int MAX_KERNEL = 3;
	localparam int FRAC_BITS  = 8;

	localparam int DATA_W  = 16;                                 // Q8.8 sample
	localparam int PROD_W  = 2 * DATA_W;                         // one product
	localparam int KDEPTH  = MAX_KERNEL * MAX_KERNEL;            // kernel entries
	localparam int LDEPTH  = MAX_KERNEL * MAX_IMAGE;             // line store entries
	localparam int ACC_W   = PROD_W + $clog2(KDEPTH);            // exact window sum
	localparam int POS_W   = $clog2(MAX_IMAGE);                  // row / column
	localparam int NSZ_W   = $clog2(MAX_IMAGE + 1);              // effective image size
	localparam int KSZ_W   = $clog2(MAX_KERNEL + 1);             // effective kernel size
	localparam int KK_W    = $clog2(KDEPTH + 1);                 // kernel entry count
	localparam int KA_W    = $clog2(KDEPTH);                     // kernel address
	localparam int LA_W    = $clog2(LDEPTH);                     // line store address
	localparam int SLOT_W  = $clog2(MAX_KERNEL);                 // row slot

	// Configuration registers
	localparam int IMG_REG_W  = 7;
	localparam int KER_REG_W  = 2;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam logic [IMG_REG_W-1:0] IMAGE_SIZE_RST  = IMG_REG_W'(8);
	localparam logic [KER_REG_W-1:0] KERNEL_SIZE_RST = KER_REG_W'(3);

	typedef enum logic [0:0] {
		REG_IMAGE_SIZE  = 1'b0,
		REG_KERNEL_SIZE = 1'b1
	} reg_idx_t;

	// Item tags
	typedef enum logic [0:0] {
		OP_KERNEL = 1'b0,
		OP_PIXEL  = 1'b1
	} op_t;

	// Accumulator control
	typedef struct packed {
		logic clear;
		logic add;
	} mac_ctrl_t;

	// Line store address of a row slot and column
	function automatic logic [LA_W-1:0] ls_addr(input logic [SLOT_W-1:0] slot,
	                                            input logic [POS_W-1:0] col);
		ls_addr = LA_W'(LA_W'(slot) * LA_W'(MAX_IMAGE) + LA_W'(col));
	endfunction

endpackage

`default_nettype wire

[rtl/conv2d_valid_q8_8_top.sv]
// conv2d_valid_q8_8_top: valid 2D cross-correlation of a square Q8.8 image, kernel and line
// store in RAM. Depends on c2d_pkg, c2d_ram and c2d_mac.
`timescale 1ns / 1ps
`default_nettype none

//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | in_valid / in_ready    | op, sample_value
//  output   | out_valid / out_ready  | out_row, out_col, conv_value, frame_done
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// Kernel loads and pixels that complete no window are stored without leaving the idle state.
// A pixel that completes a window is stored, then S_RUN makes K*K line store / kernel store
// reads feeding the single multiply-accumulate, S_TAIL adds the last product and S_DONE
// loads the output register.
// Reset clears counters and handshake state; both stores hold garbage until written.
// While the output register holds an untaken result, kernel loads and pixels that complete
// no window are still taken; the next window result waits in its last cycle with in_ready low.

module conv2d_valid_q8_8_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input items
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           op,
	input  wire logic [c2d_pkg::DATA_W-1:0]     sample_value,
	// results
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic      [c2d_pkg::POS_W-1:0]      out_row,
	output logic      [c2d_pkg::POS_W-1:0]      out_col,
	output logic      [c2d_pkg::DATA_W-1:0]     conv_value,
	output logic                                frame_done,
	// configuration
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [c2d_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [c2d_pkg::PDATA_W-1:0]    pwdata,
	output logic      [c2d_pkg::PDATA_W-1:0]    prdata,
	output logic                                pready
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_TAIL,
		S_DONE
	} state_t;

	localparam int POS_W  = c2d_pkg::POS_W;
	localparam int NSZ_W  = c2d_pkg::NSZ_W;
	localparam int KSZ_W  = c2d_pkg::KSZ_W;
	localparam int KK_W   = c2d_pkg::KK_W;
	localparam int KA_W   = c2d_pkg::KA_W;
	localparam int SLOT_W = c2d_pkg::SLOT_W;
	localparam int DATA_W = c2d_pkg::DATA_W;

	state_t                          state_q;
	logic [c2d_pkg::IMG_REG_W-1:0]   image_size_q;
	logic [c2d_pkg::KER_REG_W-1:0]   kernel_size_q;
	logic [KK_W-1:0]                 ccnt_q;
	logic [POS_W-1:0]                pr_q, pc_q;
	logic [SLOT_W-1:0]               rslot_q;
	logic                            out_valid_q;
	logic                            add_s1;

	// window walk
	logic [KSZ_W-1:0]                ki_q, kj_q;
	logic [KA_W-1:0]                 kidx_q;
	logic [SLOT_W-1:0]               slot_q;
	logic [POS_W-1:0]                col_q;

	// result payload
	logic [POS_W-1:0]                base_r_q, base_c_q;
	logic                            last_q;
	logic [POS_W-1:0]                out_row_q, out_col_q;
	logic [DATA_W-1:0]               conv_q;
	logic                            done_q;

	logic                            cfg_wr, in_xfer, pix_xfer, ker_xfer, out_load, run_last;
	logic [NSZ_W-1:0]                n_eff;
	logic [KSZ_W-1:0]                k_eff;
	logic [KK_W-1:0]                 kk, kidx_wr, kidx_inc, ccnt_nx;
	logic                            restart, win, frame_last, c_wrap, r_wrap;
	logic [POS_W-1:0]                r_cur, c_cur, r_nx, c_nx, base_r, base_c;
	logic [SLOT_W-1:0]               slot_cur, slot_nx, slot_run_nx, slot_base;
	logic [SLOT_W:0]                 slot_tmp;
	logic [DATA_W-1:0]               pix_rd, coef_rd, mac_result;
	c2d_pkg::mac_ctrl_t              mac_ctrl;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		unique case (c2d_pkg::reg_idx_t'(paddr[2]))
			c2d_pkg::REG_IMAGE_SIZE:  prdata = c2d_pkg::PDATA_W'(image_size_q);
			c2d_pkg::REG_KERNEL_SIZE: prdata = c2d_pkg::PDATA_W'(kernel_size_q);
			default:                  prdata = '0;
		endcase
	end

	// Effective sizes
	always_comb begin
		if (image_size_q == '0) begin
			n_eff = NSZ_W'(1);
		end else if (NSZ_W'(image_size_q) > NSZ_W'(c2d_pkg::MAX_IMAGE)) begin
			n_eff = NSZ_W'(c2d_pkg::MAX_IMAGE);
		end else begin
			n_eff = NSZ_W'(image_size_q);
		end
		if (kernel_size_q == '0) begin
			k_eff = KSZ_W'(1);
		end else if (KSZ_W'(kernel_size_q) > KSZ_W'(c2d_pkg::MAX_KERNEL)) begin
			k_eff = KSZ_W'(c2d_pkg::MAX_KERNEL);
		end else begin
			k_eff = KSZ_W'(kernel_size_q);
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid & in_ready;
	assign ker_xfer = in_xfer & (c2d_pkg::op_t'(op) == c2d_pkg::OP_KERNEL);
	assign pix_xfer = in_xfer & (c2d_pkg::op_t'(op) == c2d_pkg::OP_PIXEL);

	// Kernel load address: a stale counter at or past K*K writes entry 0
	assign kk       = KK_W'(k_eff) * KK_W'(k_eff);
	assign kidx_wr  = (ccnt_q >= kk) ? '0 : ccnt_q;
	assign kidx_inc = kidx_wr + KK_W'(1);
	assign ccnt_nx  = (kidx_inc >= kk) ? '0 : kidx_inc;

	// Pixel position, window test and next position
	assign restart  = (NSZ_W'(pr_q) >= n_eff) | (NSZ_W'(pc_q) >= n_eff);
	assign r_cur    = restart ? '0 : pr_q;
	assign c_cur    = restart ? '0 : pc_q;
	assign slot_cur = restart ? '0 : rslot_q;

	assign win = (NSZ_W'(k_eff) <= n_eff)
	           & (NSZ_W'(r_cur) + NSZ_W'(1) >= NSZ_W'(k_eff))
	           & (NSZ_W'(c_cur) + NSZ_W'(1) >= NSZ_W'(k_eff));
	assign base_r = r_cur - POS_W'(k_eff - KSZ_W'(1));
	assign base_c = c_cur - POS_W'(k_eff - KSZ_W'(1));
	assign frame_last = (NSZ_W'(r_cur) == n_eff - NSZ_W'(1))
	                  & (NSZ_W'(c_cur) == n_eff - NSZ_W'(1));

	assign c_wrap  = (NSZ_W'(c_cur) + NSZ_W'(1) >= n_eff);
	assign r_wrap  = (NSZ_W'(r_cur) + NSZ_W'(1) >= n_eff);
	assign c_nx    = c_wrap ? '0 : c_cur + POS_W'(1);
	assign r_nx    = !c_wrap ? r_cur : (r_wrap ? '0 : r_cur + POS_W'(1));
	assign slot_nx = !c_wrap ? slot_cur :
	                 (r_wrap ? '0 :
	                  ((slot_cur == SLOT_W'(c2d_pkg::MAX_KERNEL - 1)) ? '0
	                                                                  : slot_cur + SLOT_W'(1)));

	// Slot of the window's top row: (slot - (K-1)) mod MAX_KERNEL
	assign slot_tmp  = (SLOT_W+1)'(slot_cur) + (SLOT_W+1)'(c2d_pkg::MAX_KERNEL)
	                 - (SLOT_W+1)'(k_eff - KSZ_W'(1));
	assign slot_base = (slot_tmp >= (SLOT_W+1)'(c2d_pkg::MAX_KERNEL))
	                 ? SLOT_W'(slot_tmp - (SLOT_W+1)'(c2d_pkg::MAX_KERNEL))
	                 : SLOT_W'(slot_tmp);

	// Window walk bookkeeping
	assign run_last    = (ki_q == k_eff - KSZ_W'(1)) & (kj_q == k_eff - KSZ_W'(1));
	assign slot_run_nx = (slot_q == SLOT_W'(c2d_pkg::MAX_KERNEL - 1)) ? '0
	                                                                  : slot_q + SLOT_W'(1);
	assign out_load    = (state_q == S_DONE) & (!out_valid_q | out_ready);

	// Stores
	c2d_ram #(
		.WIDTH(DATA_W),
		.DEPTH(c2d_pkg::KDEPTH)
	) u_kernel_ram (
		.clk  (clk),
		.we   (ker_xfer),
		.waddr(KA_W'(kidx_wr)),
		.wdata(sample_value),
		.raddr(kidx_q),
		.rdata(coef_rd)
	);

	c2d_ram #(
		.WIDTH(DATA_W),
		.DEPTH(c2d_pkg::LDEPTH)
	) u_line_ram (
		.clk  (clk),
		.we   (pix_xfer),
		.waddr(c2d_pkg::ls_addr(slot_cur, c_cur)),
		.wdata(sample_value),
		.raddr(c2d_pkg::ls_addr(slot_q, col_q)),
		.rdata(pix_rd)
	);

	// Multiply-accumulate
	assign mac_ctrl.clear = pix_xfer & win;
	assign mac_ctrl.add   = add_s1;

	c2d_mac u_mac (
		.clk   (clk),
		.ctrl  (mac_ctrl),
		.pixel (pix_rd),
		.coeff (coef_rd),
		.result(mac_result)
	);

	// Sequencer, counters and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			image_size_q  <= c2d_pkg::IMAGE_SIZE_RST;
			kernel_size_q <= c2d_pkg::KERNEL_SIZE_RST;
			ccnt_q        <= '0;
			pr_q          <= '0;
			pc_q          <= '0;
			rslot_q       <= '0;
			out_valid_q   <= 1'b0;
			add_s1        <= 1'b0;
			ki_q          <= '0;
			kj_q          <= '0;
			kidx_q        <= '0;
			slot_q        <= '0;
			col_q         <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (c2d_pkg::reg_idx_t'(paddr[2]))
					c2d_pkg::REG_IMAGE_SIZE:  image_size_q  <= pwdata[c2d_pkg::IMG_REG_W-1:0];
					c2d_pkg::REG_KERNEL_SIZE: kernel_size_q <= pwdata[c2d_pkg::KER_REG_W-1:0];
					default: ;
				endcase
			end
			// output register: set on load, cleared on transfer
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			add_s1 <= (state_q == S_RUN);
			unique case (state_q)
				S_IDLE: begin
					if (ker_xfer) begin
						ccnt_q <= ccnt_nx;
					end
					if (pix_xfer) begin
						pr_q    <= r_nx;
						pc_q    <= c_nx;
						rslot_q <= slot_nx;
						if (win) begin
							ki_q        <= '0;
							kj_q        <= '0;
							kidx_q      <= '0;
							slot_q      <= slot_base;
							col_q       <= base_c;
							state_q     <= S_RUN;
						end
					end
				end
				S_RUN: begin
					kidx_q <= kidx_q + KA_W'(1);
					if (kj_q == k_eff - KSZ_W'(1)) begin
						kj_q   <= '0;
						ki_q   <= ki_q + KSZ_W'(1);
						col_q  <= base_c_q;
						slot_q <= slot_run_nx;
					end else begin
						kj_q  <= kj_q + KSZ_W'(1);
						col_q <= col_q + POS_W'(1);
					end
					if (run_last) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload, no reset needed
	always_ff @(posedge clk) begin
		if (pix_xfer && win) begin
			base_r_q <= base_r;
			base_c_q <= base_c;
			last_q   <= frame_last;
		end
		if (out_load) begin
			out_row_q <= base_r_q;
			out_col_q <= base_c_q;
			conv_q    <= mac_result;
			done_q    <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign conv_value = conv_q;
	assign frame_done = done_q;

endmodule

`default_nettype wire

[rtl/c2d_ram.sv]
// c2d_ram: generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module c2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/c2d_mac.sv]
// c2d_mac: multiply-accumulate over one window, then floor shift by 8 and 16-bit saturation.
// Depends on c2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2d_mac (
	input  wire logic                     clk,
	input  wire c2d_pkg::mac_ctrl_t       ctrl,
	input  wire logic [c2d_pkg::DATA_W-1:0] pixel,
	input  wire logic [c2d_pkg::DATA_W-1:0] coeff,
	output logic      [c2d_pkg::DATA_W-1:0] result
);

	localparam int QW = c2d_pkg::ACC_W - c2d_pkg::FRAC_BITS;

	logic signed [c2d_pkg::PROD_W-1:0] prod;
	logic signed [c2d_pkg::ACC_W-1:0]  acc_q;
	logic        [QW-1:0]              q;
	logic                              in_range;

	assign prod = $signed(pixel) * $signed(coeff);

	// Accumulator: cleared at window start, one product per cycle while add is set
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.add) begin
			acc_q <= acc_q + {{(c2d_pkg::ACC_W - c2d_pkg::PROD_W){prod[c2d_pkg::PROD_W-1]}},
			                  prod};
		end
	end

	// Arithmetic shift is a floor; saturate when the dropped high bits disagree with the sign
	assign q        = acc_q[c2d_pkg::ACC_W-1:c2d_pkg::FRAC_BITS];
	assign in_range = (&q[QW-1:c2d_pkg::DATA_W-1]) | ~(|q[QW-1:c2d_pkg::DATA_W-1]);

	always_comb begin
		if (in_range) begin
			result = q[c2d_pkg::DATA_W-1:0];
		end else if (q[QW-1]) begin
			result = {1'b1, {(c2d_pkg::DATA_W-1){1'b0}}};
		end else begin
			result = {1'b0, {(c2d_pkg::DATA_W-1){1'b1}}};
		end
	end

endmodule

`default_nettype wire
